[hdl/wnns_pkg.sv]
// ----------------------------------------------------------------------------
// wnns_pkg
// Shared widths, types and register indexes for the nearest-entry search.
// ----------------------------------------------------------------------------
`default_nettype none

package wnns_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int JOINT_COUNT = 7;
    localparam int NJ          = 7;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int JW          = 16;
    localparam int ENTRY_W     = NJ * JW;
    localparam int DIST_W      = 45;
    localparam int IDX_W       = 10;
    localparam int OCNT_W      = 11;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic       MODE_APPEND = 1'b0;
    localparam logic       MODE_QUERY  = 1'b1;

    localparam logic [NJ*16-1:0] WEIGHT_RESET =
        {16'd3314, 16'd0, 16'd7330, 16'd9144, 16'd9144, 16'd11292, 16'd12989};

    typedef struct packed {
        logic [1:0]             status;
        logic                   scan;
        logic [ADDR_W-1:0]      index;
        logic [CNT_W-1:0]       count;
        logic [NJ-1:0][JW-1:0]  joint;
    } cmd_t;

endpackage

`default_nettype wire

[hdl/wnns_if.sv]
// ----------------------------------------------------------------------------
// wnns_if
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wnns_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] joint_0;
    logic [15:0] joint_1;
    logic [15:0] joint_2;
    logic [15:0] joint_3;
    logic [15:0] joint_4;
    logic [15:0] joint_5;
    logic [15:0] joint_6;
    modport source (output valid, mode, joint_0, joint_1, joint_2, joint_3, joint_4,
                    joint_5, joint_6, input ready);
    modport sink (input valid, mode, joint_0, joint_1, joint_2, joint_3, joint_4,
                  joint_5, joint_6, output ready);
endinterface

interface wnns_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  nearest_index;
    logic [44:0] nearest_distance;
    logic [1:0]  status;
    logic [10:0] entry_count;
    modport source (output valid, nearest_index, nearest_distance, status, entry_count,
                    input ready);
    modport sink (input valid, nearest_index, nearest_distance, status, entry_count,
                  output ready);
endinterface

interface wnns_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/weighted_nearest_node_search_top.sv]
// Flow: accepted items wait in a two-entry queue; the back end pops one only when idle
// with no result held; until the queue fills, items are accepted while a query scans.
// Appends and rejected items need no scan; a query scans one stored entry per cycle
// through a registered read and a 5-stage distance pipeline.
// Reset: entry count cleared, weights restored; table contents undefined until written.
// ----------------------------------------------------------------------------
// weighted_nearest_node_search_top
// Nearest stored joint configuration under per-joint weighted squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_nearest_node_search_top (
    input  wire logic clk,
    input  wire logic rst_n,
    wnns_in_if.sink   in_ch,
    wnns_out_if.source out_ch,
    wnns_cfg_if.sink  cfg
);

    logic [wnns_pkg::NJ*16-1:0]      weights_reg;
    logic                            q_valid, q_pop;
    wnns_pkg::cmd_t                  q_head;
    logic                            st_we;
    logic [wnns_pkg::ADDR_W-1:0]     st_addr, rd_addr;
    logic [wnns_pkg::ENTRY_W-1:0]    st_data, rd_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= wnns_pkg::WEIGHT_RESET;
        end
        else if (cfg.valid && 32'(cfg.index) < wnns_pkg::NJ)
        begin
            weights_reg[cfg.index*16 +: 16] <= cfg.data;
        end
    end

    wnns_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_valid(q_valid), .q_pop(q_pop),
        .q_head(q_head), .st_we(st_we), .st_addr(st_addr), .st_data(st_data)
    );

    wnns_ram #(.WIDTH(wnns_pkg::ENTRY_W), .DEPTH(wnns_pkg::MAX_ENTRIES)) u_store (
        .clk(clk), .we(st_we), .waddr(st_addr), .wdata(st_data),
        .raddr(rd_addr), .rdata(rd_data)
    );

    wnns_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
        .rd_addr(rd_addr), .rd_data(rd_data), .weights(weights_reg), .out_ch(out_ch)
    );

endmodule

`default_nettype wire

[hdl/wnns_ram.sv]
// ----------------------------------------------------------------------------
// wnns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wnns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/wnns_front.sv]
// ----------------------------------------------------------------------------
// wnns_front
// Accept items, own the entry count, classify and queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module wnns_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    wnns_in_if.sink            in_ch,
    output logic               q_valid,
    input  wire logic          q_pop,
    output wnns_pkg::cmd_t     q_head,
    output logic               st_we,
    output logic [wnns_pkg::ADDR_W-1:0]  st_addr,
    output logic [wnns_pkg::ENTRY_W-1:0] st_data
);

    wnns_pkg::cmd_t             q_reg [2];
    logic                       wr_reg, rd_reg;
    logic [1:0]                 fill_reg;
    logic [wnns_pkg::CNT_W-1:0] count_reg;
    logic                       acc;
    wnns_pkg::cmd_t             cmd;
    logic                       full;

    assign full        = (count_reg == wnns_pkg::CNT_W'(wnns_pkg::MAX_ENTRIES));
    assign in_ch.ready = (fill_reg != 2'd2);
    assign acc         = in_ch.valid && in_ch.ready;
    assign q_valid     = (fill_reg != 2'd0);
    assign q_head      = q_reg[rd_reg];

    always_comb
    begin
        cmd.joint = {in_ch.joint_6, in_ch.joint_5, in_ch.joint_4, in_ch.joint_3,
                     in_ch.joint_2, in_ch.joint_1, in_ch.joint_0};
        cmd.scan  = 1'b0;
        cmd.index = '0;
        cmd.status = wnns_pkg::ST_OK;
        cmd.count = count_reg;
        if (in_ch.mode == wnns_pkg::MODE_APPEND)
        begin
            if (full)
            begin
                cmd.status = wnns_pkg::ST_FULL;
            end
            else
            begin
                cmd.index = count_reg[wnns_pkg::ADDR_W-1:0];
                cmd.count = count_reg + 1'b1;
            end
        end
        else if (count_reg == '0)
        begin
            cmd.status = wnns_pkg::ST_EMPTY;
        end
        else
        begin
            cmd.scan = 1'b1;
        end
    end

    assign st_we   = acc && (in_ch.mode == wnns_pkg::MODE_APPEND) && !full;
    assign st_addr = count_reg[wnns_pkg::ADDR_W-1:0];
    assign st_data = cmd.joint;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            fill_reg  <= 2'd0;
            count_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                wr_reg    <= ~wr_reg;
                count_reg <= cmd.count;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            fill_reg <= fill_reg + {1'b0, acc} - {1'b0, q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fill_reg == 2'd2 && acc)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wnns_pkg::CNT_W'(wnns_pkg::MAX_ENTRIES)) else $error("count overrun");
`endif

endmodule

`default_nettype wire

[hdl/wnns_back.sv]
// ----------------------------------------------------------------------------
// wnns_back
// Scan stored entries through a pipelined weighted distance and pick the minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module wnns_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire wnns_pkg::cmd_t q_head,
    output logic [wnns_pkg::ADDR_W-1:0]  rd_addr,
    input  wire logic [wnns_pkg::ENTRY_W-1:0] rd_data,
    input  wire logic [wnns_pkg::NJ*16-1:0]   weights,
    wnns_out_if.source         out_ch
);

    localparam int NJ = wnns_pkg::NJ;
    localparam int LAT = 6;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_OUT} state_t;

    state_t                      state_reg;
    wnns_pkg::cmd_t              cmd_reg;
    logic [wnns_pkg::CNT_W-1:0]  addr_reg;
    logic [LAT-1:0]              vld_reg;
    logic [wnns_pkg::ADDR_W-1:0] idx_pipe_reg [LAT];
    logic signed [16:0]          diff_reg [NJ];
    logic signed [33:0]          prod_reg [NJ];
    logic [21:0]                 mag_reg [NJ];
    logic [43:0]                 sq_reg [NJ];
    logic [wnns_pkg::DIST_W-1:0] sum_reg;
    logic [wnns_pkg::DIST_W-1:0] best_reg;
    logic [wnns_pkg::ADDR_W-1:0] best_idx_reg;
    logic                        have_reg;
    logic                        out_valid_reg;
    logic [wnns_pkg::ADDR_W-1:0] o_idx_reg;
    logic [wnns_pkg::DIST_W-1:0] o_dist_reg;
    logic [1:0]                  o_st_reg;
    logic [wnns_pkg::CNT_W-1:0]  o_cnt_reg;
    logic                        issue;
    logic [wnns_pkg::DIST_W-1:0] sum_c;

    assign issue   = (state_reg == S_SCAN) && (addr_reg < cmd_reg.count);
    assign rd_addr = addr_reg[wnns_pkg::ADDR_W-1:0];
    assign q_pop   = (state_reg == S_IDLE) && q_valid && !out_valid_reg;

    always_comb
    begin
        sum_c = '0;
        for (int j = 0; j < wnns_pkg::JOINT_COUNT; j++)
        begin
            sum_c = sum_c + wnns_pkg::DIST_W'(sq_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_pipe_reg[0] <= addr_reg[wnns_pkg::ADDR_W-1:0];
        for (int k = 1; k < LAT; k++)
        begin
            idx_pipe_reg[k] <= idx_pipe_reg[k-1];
        end
        for (int j = 0; j < NJ; j++)
        begin
            diff_reg[j] <= 17'(signed'(cmd_reg.joint[j])) - 17'(signed'(rd_data[j*16 +: 16]));
            prod_reg[j] <= 34'(diff_reg[j]) * 34'(signed'({1'b0, weights[j*16 +: 16]}));
            mag_reg[j]  <= prod_reg[j][33] ? 22'((-prod_reg[j] + 34'sd4095) >>> 12)
                                           : 22'(prod_reg[j] >>> 12);
            sq_reg[j]   <= 44'(mag_reg[j]) * 44'(mag_reg[j]);
        end
        sum_reg <= sum_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], issue};
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (vld_reg[LAT-1] && (!have_reg || sum_reg < best_reg))
            begin
                have_reg     <= 1'b1;
                best_reg     <= sum_reg;
                best_idx_reg <= idx_pipe_reg[LAT-1];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg  <= q_head;
                        addr_reg <= '0;
                        have_reg <= 1'b0;
                        if (q_head.scan)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            o_idx_reg     <= q_head.index;
                            o_dist_reg    <= '0;
                            o_st_reg      <= q_head.status;
                            o_cnt_reg     <= q_head.count;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (vld_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    o_idx_reg     <= best_idx_reg;
                    o_dist_reg    <= best_reg;
                    o_st_reg      <= wnns_pkg::ST_OK;
                    o_cnt_reg     <= cmd_reg.count;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.nearest_index    = wnns_pkg::IDX_W'(o_idx_reg);
    assign out_ch.nearest_distance = o_dist_reg;
    assign out_ch.status           = o_st_reg;
    assign out_ch.entry_count      = wnns_pkg::OCNT_W'(o_cnt_reg);

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE && !out_valid_reg) else $error("pop while busy");
    a_no_issue_out: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> !out_valid_reg) else $error("scan while result held");
    a_out_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> have_reg) else $error("query finished with no entry");
`endif

endmodule

`default_nettype wire

[tb/sv/weighted_nearest_node_search_top_tb.sv]
// ----------------------------------------------------------------------------
// weighted_nearest_node_search_top_tb
// Drives appends and nearest-entry queries through the item channel, writes
// the joint weights between phases, and checks every result against a
// predicted table scan kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module weighted_nearest_node_search_top_tb;

    typedef struct packed {
        logic        mode;
        logic [wnns_pkg::NJ-1:0][15:0] joint;
    } item_t;

    typedef struct packed {
        logic [9:0]  nearest_index;
        logic [44:0] nearest_distance;
        logic [1:0]  status;
        logic [10:0] entry_count;
    } result_t;

    class search_board;
        logic signed [15:0] table_q[$][wnns_pkg::NJ];
        logic [15:0]        weight[wnns_pkg::NJ];
        result_t            pending[$];
        int                 mismatches;

        function new();
            for (int j = 0; j < wnns_pkg::NJ; j++)
                weight[j] = wnns_pkg::WEIGHT_RESET[j*16 +: 16];
            mismatches = 0;
        endfunction

        function logic [63:0] term_sq(logic signed [16:0] diff, logic [15:0] w);
            logic signed [40:0] p;
            logic [40:0]        mag;
            p = diff * $signed({1'b0, w});
            if (p >= 0)
                mag = p >>> 12;
            else
                mag = (-p + 4095) >> 12;
            return mag * mag;
        endfunction

        function void note_item(item_t it);
            result_t r;
            logic signed [15:0] row[wnns_pkg::NJ];
            logic [63:0] sum;
            r = '0;
            if (it.mode == wnns_pkg::MODE_APPEND) begin
                if (table_q.size() < wnns_pkg::MAX_ENTRIES) begin
                    for (int j = 0; j < wnns_pkg::NJ; j++)
                        row[j] = it.joint[j];
                    r.nearest_index = 10'(table_q.size());
                    table_q.insert(table_q.size(), row);
                end
                else
                    r.status = wnns_pkg::ST_FULL;
            end
            else if (table_q.size() == 0)
                r.status = wnns_pkg::ST_EMPTY;
            else begin
                for (int i = 0; i < table_q.size(); i++) begin
                    sum = 0;
                    for (int j = 0; j < wnns_pkg::JOINT_COUNT; j++)
                        sum += term_sq(17'($signed(it.joint[j])) - 17'(table_q[i][j]),
                                       weight[j]);
                    if (i == 0 || sum < r.nearest_distance) begin
                        r.nearest_distance = 45'(sum);
                        r.nearest_index = 10'(i);
                    end
                end
            end
            r.entry_count = 11'(table_q.size());
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    search_board board;
    int  stall_hold;

    wnns_in_if  in_ch();
    wnns_out_if out_ch();
    wnns_cfg_if cfg();

    weighted_nearest_node_search_top dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // input accept and result check
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_item({in_ch.mode, in_ch.joint_6, in_ch.joint_5, in_ch.joint_4,
                             in_ch.joint_3, in_ch.joint_2, in_ch.joint_1, in_ch.joint_0});
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result({out_ch.nearest_index, out_ch.nearest_distance,
                                out_ch.status, out_ch.entry_count});
    end

    // receiver stall pattern, with long hold-offs on request
    initial
    begin
        int phase;
        out_ch.ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_hold > 0) begin
                stall_hold--;
                out_ch.ready <= 1'b0;
            end
            else begin
                phase = (phase + 1) % 64;
                if (phase < 20)
                    out_ch.ready <= 1'b1;
                else
                    out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    int burst_left;

    task automatic send_item(item_t it);
        int gap;
        while (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= it.mode;
        in_ch.joint_0 <= it.joint[0];
        in_ch.joint_1 <= it.joint[1];
        in_ch.joint_2 <= it.joint[2];
        in_ch.joint_3 <= it.joint[3];
        in_ch.joint_4 <= it.joint[4];
        in_ch.joint_5 <= it.joint[5];
        in_ch.joint_6 <= it.joint[6];
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (wnns_pkg::MAX_ENTRIES + 20) @(posedge clk);
    endtask

    task automatic write_weight(logic [wnns_pkg::CFG_IDX_W-1:0] idx, logic [15:0] w);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= w;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx < wnns_pkg::NJ)
            board.weight[idx] = w;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_joint(int kind);
        case (kind)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic item_t rand_item(logic mode, int kind);
        item_t it;
        it.mode = mode;
        for (int j = 0; j < wnns_pkg::NJ; j++)
            it.joint[j] = rand_joint(kind == 4 ? $urandom_range(0, 3) : kind);
        return it;
    endfunction

    initial
    begin
        item_t it;
        board = new();
        stall_hold = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = wnns_pkg::MODE_APPEND;
        {in_ch.joint_0, in_ch.joint_1, in_ch.joint_2, in_ch.joint_3,
         in_ch.joint_4, in_ch.joint_5, in_ch.joint_6} = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes, ties, then queries at reset weights
        send_item(rand_item(wnns_pkg::MODE_QUERY, 3));
        send_item(rand_item(wnns_pkg::MODE_APPEND, 0));
        send_item(rand_item(wnns_pkg::MODE_APPEND, 1));
        send_item(rand_item(wnns_pkg::MODE_APPEND, 1));
        send_item(rand_item(wnns_pkg::MODE_QUERY, 0));
        send_item(rand_item(wnns_pkg::MODE_QUERY, 1));
        send_item(rand_item(wnns_pkg::MODE_QUERY, 2));
        send_item(rand_item(wnns_pkg::MODE_APPEND, 2));
        send_item(rand_item(wnns_pkg::MODE_QUERY, 3));
        settle();

        // extreme weights, including an out-of-range index
        for (int j = 0; j < wnns_pkg::NJ; j++)
            write_weight(3'(j), 16'hffff);
        write_weight(3'd7, 16'h1234);
        send_item(rand_item(wnns_pkg::MODE_QUERY, 0));
        send_item(rand_item(wnns_pkg::MODE_QUERY, 1));
        send_item(rand_item(wnns_pkg::MODE_QUERY, 4));
        settle();
        for (int j = 0; j < wnns_pkg::NJ; j++)
            write_weight(3'(j), 16'h0000);
        send_item(rand_item(wnns_pkg::MODE_QUERY, 4));
        settle();

        // random phases; hold off the receiver once so the input stalls
        for (int ph = 0; ph < 4; ph++) begin
            for (int j = 0; j < wnns_pkg::NJ; j++)
                write_weight(3'(j), 16'($urandom()));
            if (ph == 1)
                stall_hold = 3000;
            for (int k = 0; k < 140; k++) begin
                it = rand_item($urandom_range(0, 3) == 0, 4);
                send_item(it);
            end
            settle();
        end

        // query once more with joint 5 weighted
        write_weight(3'd5, 16'h1000);
        send_item(rand_item(wnns_pkg::MODE_QUERY, 3));
        send_item(rand_item(wnns_pkg::MODE_QUERY, 4));
        settle();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
hdl/wnns_pkg.sv
hdl/wnns_if.sv
hdl/wnns_ram.sv
hdl/wnns_front.sv
hdl/wnns_back.sv
hdl/weighted_nearest_node_search_top.sv
tb/sv/weighted_nearest_node_search_top_tb.sv
